FILE: sv/pfre_pkg.sv
// ----------------------------------------------------------------------------
// pfre_pkg
// Shared widths, codes and controller/datapath types of the page frame
// replacement engine.
// ----------------------------------------------------------------------------
package pfre_pkg;

	localparam int FRAMES_DEF = 8;

	localparam int PAGE_W  = 20;
	localparam int POL_W   = 2;
	localparam int FC_W    = 4;
	localparam int OUTC_W  = 2;
	localparam int FIDX_W  = 3;
	localparam int FAULT_W = 32;
	localparam int CFG_IW  = 1;
	localparam int CFG_DW  = 4;

	localparam logic [CFG_IW-1:0] CFG_POLICY      = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_FRAME_COUNT = 1'b1;

	localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
	localparam logic [POL_W-1:0] POL_CLOCK = 2'd1;
	localparam logic [POL_W-1:0] POL_LRU   = 2'd2;

	localparam logic [OUTC_W-1:0] OUT_HIT  = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_FILL = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_REPL = 2'd2;

	localparam logic [FC_W-1:0] FC_RESET = 4'd8;

	typedef struct packed {
		logic idle;
		logic accept;
		logic look;
		logic scan;
		logic apply;
	} pfre_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic need_scan;
		logic scan_done;
		logic out_free;
	} pfre_sts_t;

endpackage

FILE: sv/pfre_if.sv
// ----------------------------------------------------------------------------
// pfre_if
// Valid/ready channels of the page frame replacement engine: reference
// input, result output and configuration write.
// ----------------------------------------------------------------------------
interface pfre_in_if import pfre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page_number;

	modport source (output valid, output page_number, input ready);
	modport sink   (input valid, input page_number, output ready);
endinterface

interface pfre_out_if import pfre_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OUTC_W-1:0]  outcome;
	logic [FIDX_W-1:0]  frame_index;
	logic [PAGE_W-1:0]  evicted_page;
	logic [FAULT_W-1:0] fault_total;

	modport source (output valid, output outcome, output frame_index,
		output evicted_page, output fault_total, input ready);
	modport sink   (input valid, input outcome, input frame_index,
		input evicted_page, input fault_total, output ready);
endinterface

interface pfre_cfg_if import pfre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/pfre_ctrl.sv
// ----------------------------------------------------------------------------
// pfre_ctrl
// Sequencer: accept, lookup, optional victim scan, apply and result load.
// ----------------------------------------------------------------------------
module pfre_ctrl import pfre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pfre_sts_t sts,
	output pfre_cmd_t cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_LOOK  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_APPLY = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		cmd.idle   = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (sts.in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sts.need_scan ? S_SCAN : S_APPLY;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done)
					state_d = S_APPLY;
			end
			S_APPLY: begin
				if (sts.out_free) begin
					cmd.apply = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: sv/pfre_dp.sv
// ----------------------------------------------------------------------------
// pfre_dp
// Datapath: frame table, parallel lookup, use bits, recency ranks, hand,
// fault counter, configuration registers and result register.
// ----------------------------------------------------------------------------
module pfre_dp import pfre_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfre_cmd_t         cmd,
	output pfre_sts_t         sts,
	input  logic              in_valid,
	input  logic [PAGE_W-1:0] in_page,
	pfre_cfg_if.sink          cfg,
	pfre_out_if.source        rsp
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);
	localparam int RW = FW;
	localparam int NW = (CW > FC_W) ? CW : FC_W;
	localparam logic [NW-1:0] FRAMES_N = NW'(FRAMES);
	localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);

	logic [POL_W-1:0]   policy_q;
	logic [FC_W-1:0]    frame_count_q;
	logic [PAGE_W-1:0]  frame_page_q [FRAMES];
	logic [CW-1:0]      filled_q;
	logic [FW-1:0]      hand_q;
	logic [FRAMES-1:0]  use_q;
	logic [RW-1:0]      rank_q [FRAMES];
	logic [FAULT_W-1:0] fault_q;

	logic [PAGE_W-1:0]  page_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      v_q;
	logic [OUTC_W-1:0]  kind_q;
	logic [FW-1:0]      frame_q;
	logic [CW-1:0]      scan_q;
	logic [RW-1:0]      best_q;

	logic               out_valid_q;
	logic [OUTC_W-1:0]  outcome_q;
	logic [FIDX_W-1:0]  frame_index_q;
	logic [PAGE_W-1:0]  evicted_q;
	logic [FAULT_W-1:0] fault_total_q;

	logic [NW-1:0]      fc_ext;
	logic [CW-1:0]      n_c;
	logic [CW-1:0]      v_c;
	logic [FW-1:0]      hand_fix;
	logic               hit_c;
	logic [FW-1:0]      hit_idx;
	logic               clk_done;
	logic               lru_last;
	logic [FW-1:0]      hand_inc;
	logic [FW-1:0]      frame_inc;
	logic [CW-1:0]      touch_lim;
	logic               touch_all;
	logic [RW-1:0]      rank_f;
	logic [FAULT_W-1:0] fault_inc;
	logic               out_free;

	assign cfg.ready = 1'b1;

	assign fc_ext = NW'(frame_count_q);

	always_comb begin
		if (fc_ext == '0)
			n_c = CW'(1);
		else if (fc_ext > FRAMES_N)
			n_c = CW'(FRAMES);
		else
			n_c = CW'(fc_ext);
		v_c      = (filled_q < n_c) ? filled_q : n_c;
		hand_fix = (CW'(hand_q) >= n_c) ? '0 : hand_q;
	end

	always_comb begin
		hit_c   = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (!hit_c && (CW'(i) < v_c) && (frame_page_q[i] == page_q)) begin
				hit_c   = 1'b1;
				hit_idx = FW'(i);
			end
		end
	end

	assign clk_done  = (scan_q == n_q) || !use_q[hand_q];
	assign lru_last  = (scan_q == (n_q - CW'(1)));
	assign hand_inc  = ((CW'(hand_q) + CW'(1)) == n_q) ? '0 : hand_q + FW'(1);
	assign frame_inc = ((CW'(frame_q) + CW'(1)) == n_q) ? '0 : frame_q + FW'(1);
	assign rank_f    = rank_q[frame_q];
	assign touch_all = (kind_q != OUT_HIT);
	assign fault_inc = (fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		case (kind_q)
			OUT_HIT:  touch_lim = v_q;
			OUT_FILL: touch_lim = v_q + CW'(1);
			default:  touch_lim = n_q;
		endcase
	end

	always_comb begin
		sts.in_valid  = in_valid;
		sts.need_scan = !hit_c && (v_c >= n_c) &&
			((policy_q == POL_CLOCK) || (policy_q == POL_LRU));
		sts.scan_done = (policy_q == POL_CLOCK) ? clk_done : lru_last;
		sts.out_free  = out_free;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= POL_FIFO;
			frame_count_q <= FC_RESET;
			filled_q      <= '0;
			hand_q        <= '0;
			use_q         <= '0;
			fault_q       <= '0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < FRAMES; i++)
				rank_q[i] <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_POLICY:      policy_q      <= cfg.data[POL_W-1:0];
					CFG_FRAME_COUNT: frame_count_q <= cfg.data[FC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.look)
				hand_q <= hand_fix;
			if (cmd.scan && (policy_q == POL_CLOCK) && !clk_done) begin
				use_q[hand_q] <= 1'b0;
				hand_q        <= hand_inc;
			end
			if (cmd.apply) begin
				use_q[frame_q] <= 1'b1;
				for (int i = 0; i < FRAMES; i++) begin
					if ((CW'(i) < touch_lim) && (FW'(i) != frame_q) &&
						(touch_all || (rank_q[i] < rank_f)) && (rank_q[i] != RANK_MAX))
						rank_q[i] <= rank_q[i] + RW'(1);
				end
				rank_q[frame_q] <= '0;
				if (kind_q == OUT_FILL) begin
					filled_q <= v_q + CW'(1);
					hand_q   <= frame_inc;
				end
				if (kind_q == OUT_REPL) begin
					fault_q <= fault_inc;
					if (policy_q != POL_LRU)
						hand_q <= frame_inc;
				end
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (cmd.accept)
			page_q <= in_page;
		if (cmd.look) begin
			n_q    <= n_c;
			v_q    <= v_c;
			scan_q <= '0;
			if (hit_c) begin
				kind_q  <= OUT_HIT;
				frame_q <= hit_idx;
			end else if (v_c < n_c) begin
				kind_q  <= OUT_FILL;
				frame_q <= FW'(v_c);
			end else begin
				kind_q  <= OUT_REPL;
				frame_q <= hand_fix;
			end
		end
		if (cmd.scan) begin
			scan_q <= scan_q + CW'(1);
			if (policy_q == POL_CLOCK) begin
				if (clk_done)
					frame_q <= hand_q;
			end else if ((scan_q == '0) || (rank_q[scan_q[FW-1:0]] > best_q)) begin
				best_q  <= rank_q[scan_q[FW-1:0]];
				frame_q <= scan_q[FW-1:0];
			end
		end
		if (cmd.apply) begin
			if (kind_q != OUT_HIT)
				frame_page_q[frame_q] <= page_q;
			outcome_q     <= kind_q;
			frame_index_q <= FIDX_W'(frame_q);
			evicted_q     <= (kind_q == OUT_REPL) ? frame_page_q[frame_q] : '0;
			fault_total_q <= (kind_q == OUT_REPL) ? fault_inc : fault_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.outcome      = outcome_q;
	assign rsp.frame_index  = frame_index_q;
	assign rsp.evicted_page = evicted_q;
	assign rsp.fault_total  = fault_total_q;

endmodule

FILE: sv/page_frame_replacement_engine.sv
// ----------------------------------------------------------------------------
// page_frame_replacement_engine
// Page reference checker with FIFO, CLOCK and LRU replacement over a set of
// frames; reports hit, fill or replace, frame, evicted page and fault count.
//
// channel  dir  handshake          payload
// cfg      in   valid/ready        index, data (0 policy, 1 frame_count)
// req      in   valid/ready        page_number
// rsp      out  valid/ready        outcome, frame_index, evicted_page,
//                                  fault_total
//
// One reference at a time. Hit, fill and FIFO replace pass through accept,
// lookup and apply. CLOCK replace adds a sweep of the hand over the use
// bits; LRU replace adds a rank scan over the active frames. The result
// register lets the next reference enter while a result waits; apply stalls
// until that register is free. cfg is always ready.
// Reset is asynchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module page_frame_replacement_engine import pfre_pkg::*; #(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pfre_cfg_if.sink   cfg,
	pfre_in_if.sink    req,
	pfre_out_if.source rsp
);

	pfre_cmd_t cmd;
	pfre_sts_t sts;

	assign req.ready = cmd.idle;

	pfre_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pfre_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_valid (req.valid),
		.in_page  (req.page_number),
		.cfg      (cfg),
		.rsp      (rsp)
	);

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for page_frame_replacement_engine. A directed table
// covers hits, fills, replacement under each policy, the spare policy code
// and out-of-range frame counts. Random phases then reprogram policy and
// frame count and send references drawn mostly from a small working set.
// Each result is checked against a typed table row or an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pfre_pkg::*;

	localparam int NF = FRAMES_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int TOTAL_REFS = 1250;
	localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

	typedef struct packed {
		logic [OUTC_W-1:0]  outcome;
		logic [FIDX_W-1:0]  frame;
		logic [PAGE_W-1:0]  evicted;
		logic [FAULT_W-1:0] faults;
	} frame_result_t;

	typedef enum logic {ROW_REGS, ROW_PAGE} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [POL_W-1:0]   pol;
		logic [FC_W-1:0]    count;
		logic [PAGE_W-1:0]  page;
		logic               typed;
		logic [OUTC_W-1:0]  w_outcome;
		logic [FIDX_W-1:0]  w_frame;
		logic [PAGE_W-1:0]  w_evicted;
		logic [FAULT_W-1:0] w_faults;
	} drill_row_t;

	logic clk;
	logic arst_n;
	bit   steady;
	int   errors;
	int   sent;
	int   idle_cycles;

	pfre_cfg_if cfg();
	pfre_in_if  req();
	pfre_out_if rsp();

	page_frame_replacement_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	// frame state model
	logic [POL_W-1:0]   cur_policy = POL_FIFO;
	logic [FC_W-1:0]    cur_count  = FC_RESET;
	logic [PAGE_W-1:0]  held_page [NF];
	bit                 use_bit [NF];
	int unsigned        age [NF];
	int unsigned        filled = 0;
	int unsigned        hand = 0;
	logic [FAULT_W-1:0] faults = '0;

	frame_result_t frame_results_due [$];
	frame_result_t due;
	drill_row_t    drill [$];
	logic [PAGE_W-1:0] pool [16];

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void age_frames(input int unsigned f, input int unsigned lim,
		input int unsigned old_age);
		for (int i = 0; i < lim; i++) begin
			if (i != f && age[i] < old_age && age[i] < NF - 1)
				age[i]++;
		end
		age[f] = 0;
	endfunction

	function automatic frame_result_t next_frame_result(input logic [PAGE_W-1:0] page);
		int unsigned n, v, f, best, steps;
		bit hit;
		frame_result_t r;
		n = (cur_count == 0) ? 1 : ((cur_count > NF) ? NF : cur_count);
		v = (filled < n) ? filled : n;
		hit = 1'b0;
		f = 0;
		r = '0;
		r.outcome = OUT_HIT;
		if (hand >= n)
			hand = 0;
		for (int i = 0; i < v; i++) begin
			if (!hit && held_page[i] == page) begin
				hit = 1'b1;
				f = i;
			end
		end
		if (hit) begin
			use_bit[f] = 1'b1;
			age_frames(f, v, age[f]);
		end else if (v < n) begin
			f = v;
			held_page[f] = page;
			use_bit[f] = 1'b1;
			age_frames(f, v + 1, NF);
			filled = v + 1;
			hand = (f + 1) % n;
			r.outcome = OUT_FILL;
		end else begin
			if (cur_policy == POL_CLOCK) begin
				steps = 0;
				while (steps < n && use_bit[hand]) begin
					use_bit[hand] = 1'b0;
					hand = (hand + 1) % n;
					steps++;
				end
				f = hand;
				hand = (f + 1) % n;
			end else if (cur_policy == POL_LRU) begin
				best = 0;
				f = 0;
				for (int i = 0; i < n; i++) begin
					if (i == 0 || age[i] > best) begin
						best = age[i];
						f = i;
					end
				end
			end else begin
				f = hand;
				hand = (f + 1) % n;
			end
			r.evicted = held_page[f];
			held_page[f] = page;
			use_bit[f] = 1'b1;
			age_frames(f, n, NF);
			if (faults != '1)
				faults++;
			r.outcome = OUT_REPL;
		end
		r.frame = f[FIDX_W-1:0];
		r.faults = faults;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_ref(input logic [PAGE_W-1:0] page, input logic typed,
		input frame_result_t want);
		frame_result_t r;
		while (!steady && $urandom_range(0, 99) < 17) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.page_number <= page;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		r = next_frame_result(page);
		frame_results_due.push_back(typed ? want : r);
		sent++;
	endtask

	// drains the block, then writes policy and frame count
	task automatic program_regs(input logic [POL_W-1:0] pol, input logic [FC_W-1:0] count);
		req.valid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= CFG_POLICY;
		cfg.data <= CFG_DW'(pol);
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cur_policy = pol;
		cfg.index <= CFG_FRAME_COUNT;
		cfg.data <= count;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cur_count = count;
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [PAGE_W-1:0] pick_page(input int span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return pool[$urandom_range(0, span - 1)];
		if (r < 90)
			return PAGE_W'($urandom);
		if (r < 95)
			return PAGE_W'(1) << $urandom_range(0, PAGE_W - 1);
		return ~(PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
	endfunction

	always @(posedge clk) begin
		if (arst_n)
			rsp.ready <= steady || ($urandom_range(0, 99) >= 17);
	end

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			if (frame_results_due.size() == 0) begin
				report("unexpected result, outcome", 32'(rsp.outcome), 32'd0);
			end else begin
				due = frame_results_due.pop_front();
				if (rsp.outcome !== due.outcome)
					report("outcome", 32'(rsp.outcome), 32'(due.outcome));
				if (rsp.frame_index !== due.frame)
					report("frame_index", 32'(rsp.frame_index), 32'(due.frame));
				if (rsp.evicted_page !== due.evicted)
					report("evicted_page", 32'(rsp.evicted_page), 32'(due.evicted));
				if (rsp.fault_total !== due.faults)
					report("fault_total", rsp.fault_total, due.faults);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
			|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("page_frame_replacement_engine: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int n, span, batch;
		logic [POL_W-1:0] pol;
		logic [FC_W-1:0] count;
		arst_n = 1'b0;
		steady = 1'b0;
		errors = 0;
		sent = 0;
		idle_cycles = 0;
		req.valid = 1'b0;
		req.page_number = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		rsp.ready = 1'b0;
		for (int k = 0; k < NF; k++) begin
			held_page[k] = '0;
			use_bit[k] = 1'b0;
			age[k] = 0;
		end

		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00000, 1'b1, OUT_FILL, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'hFFFFF, 1'b1, OUT_FILL, 3'd1, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00000, 1'b1, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_REGS, POL_FIFO, 4'd2, 20'h0, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h12345, 1'b1, OUT_REPL, 3'd0, 20'h00000,
			32'd1});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h54321, 1'b1, OUT_REPL, 3'd1, 20'hFFFFF,
			32'd2});
		drill.push_back('{ROW_REGS, POL_SPARE, 4'd2, 20'h0, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'hABCDE, 1'b1, OUT_REPL, 3'd0, 20'h12345,
			32'd3});
		drill.push_back('{ROW_REGS, POL_CLOCK, 4'd2, 20'h0, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h54321, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00001, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'hABCDE, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00002, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_REGS, POL_LRU, 4'd2, 20'h0, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00001, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00003, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_REGS, POL_LRU, 4'd0, 20'h0, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00004, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h00004, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_REGS, POL_LRU, 4'd15, 20'h0, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h80000, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h40000, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h20000, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h0AAAA, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h05555, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h7FFFF, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h80000, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'hFFFFE, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_REGS, POL_FIFO, 4'd8, 20'h0, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});
		drill.push_back('{ROW_PAGE, POL_FIFO, 4'd0, 20'h12121, 1'b0, OUT_HIT, 3'd0, 20'h0, 32'd0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill[i]) begin
			if (drill[i].kind == ROW_REGS)
				program_regs(drill[i].pol, drill[i].count);
			else
				send_ref(drill[i].page, drill[i].typed, {drill[i].w_outcome, drill[i].w_frame,
					drill[i].w_evicted, drill[i].w_faults});
		end

		for (int k = 0; k < 16; k++)
			pool[k] = PAGE_W'($urandom);

		for (int p = 0; sent < TOTAL_REFS; p++) begin
			case (p % 6)
				0: count = 4'd1;
				1: count = 4'd8;
				2: count = 4'd0;
				3: count = 4'd15;
				default: count = FC_W'($urandom_range(0, 15));
			endcase
			pol = (p < 8) ? POL_W'(p % 4) : POL_W'($urandom_range(0, 3));
			program_regs(pol, count);
			steady = (p >= 12 && p < 16);
			n = (count == 0) ? 1 : ((count > NF) ? NF : count);
			span = n + $urandom_range(0, 4);
			if (span > 16)
				span = 16;
			for (int k = 0; k < 16; k++) begin
				if ($urandom_range(0, 2) == 0)
					pool[k] = PAGE_W'($urandom);
			end
			batch = $urandom_range(10, 60);
			for (int j = 0; j < batch; j++)
				send_ref(pick_page(span), 1'b0, '0);
		end
		steady = 1'b0;

		req.valid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("page_frame_replacement_engine: match");
		else
			$display("page_frame_replacement_engine: mismatch");
		$finish;
	end

endmodule

FILE: page_frame_replacement_engine.f
sv/pfre_pkg.sv
sv/pfre_if.sv
sv/pfre_ctrl.sv
sv/pfre_dp.sv
sv/page_frame_replacement_engine.sv
bench/testbench.sv
